FILE: src/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types and constants for the letter pair substitution pipeline.
// ----------------------------------------------------------------------------
package pf_pkg;

	localparam int unsigned SqDim   = 5;
	localparam int unsigned SqCells = SqDim * SqDim;
	localparam int unsigned CellW   = 5;
	localparam int unsigned PosW    = 3;
	localparam int unsigned RegW    = 60;
	localparam int unsigned LowCells = 12;

	localparam logic [CellW-1:0] CodeI   = 5'd8;
	localparam logic [CellW-1:0] CodeJ   = 5'd9;
	localparam logic [CellW-1:0] CodeX   = 5'd23;
	localparam logic [CellW-1:0] CodeMax = 5'd25;

	localparam logic [1:0] RegCellsLow  = 2'd0;
	localparam logic [1:0] RegCellsHigh = 2'd1;
	localparam logic [1:0] RegCellLast  = 2'd2;

	localparam logic OpEncrypt = 1'b0;
	localparam logic OpDecrypt = 1'b1;

	typedef logic [SqCells-1:0][CellW-1:0] cell_arr_t;

	// Position of a letter in the key square.
	typedef struct packed {
		logic            found;
		logic [PosW-1:0] row;
		logic [PosW-1:0] col;
	} loc_t;

	// One substituted pair.
	typedef struct packed {
		logic             bad;
		logic [CellW-1:0] second;
		logic [CellW-1:0] first;
	} res_t;

endpackage

FILE: src/playfair_digraph_cipher_top.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top
// Letter pair substitution against a 5x5 key square held in registers.
//
//   channel | direction | tdata (low bit up)                     | tuser
//   s_*     | in        | first_letter, second_letter,           | op
//           |           | second_present, 5 zero bits            |
//   m_*     | out       | out_first, out_second, 6 zero bits     | bad_letter
//   cfg_*   | in        | write enable, register index, 60-bit data
//
// One pair per cycle while the output is not stalled; a pair is held first
// in the input register, which feeds the square search and substitution
// directly, and then in the result register, which holds the answer.
// Reset clears the key square to zero and empties both stages.
// A stalled result does not block intake while the input stage is free.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_top
	import pf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // first_letter, second_letter, second_present
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_first, out_second
	output logic        m_tuser,   // bad_letter
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [59:0] cfg_wdata
);

	logic [RegW-1:0]  cells_low_q, cells_high_q;
	logic [CellW-1:0] cell_last_q;
	cell_arr_t        cells;

	logic             v_s1, v_s2;
	logic             op_s1;
	logic [CellW-1:0] a_s1, b_s1;
	res_t             res_s2;

	logic             adv1, adv2;
	logic [CellW-1:0] a_in, b_raw, b_in;
	loc_t             loc_a, loc_b;
	res_t             res;

	// Key square registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_low_q  <= '0;
			cells_high_q <= '0;
			cell_last_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegCellsLow:  cells_low_q  <= cfg_wdata;
				RegCellsHigh: cells_high_q <= cfg_wdata;
				RegCellLast:  cell_last_q  <= cfg_wdata[CellW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < LowCells; k++) begin
			cells[k]            = cells_low_q[k * CellW +: CellW];
			cells[k + LowCells] = cells_high_q[k * CellW +: CellW];
		end
		cells[SqCells - 1] = cell_last_q;
	end

	// Input preparation: j folds into i, a missing second letter becomes x.
	assign a_in  = (s_tdata[4:0] == CodeJ) ? CodeI : s_tdata[4:0];
	assign b_raw = (s_tdata[9:5] == CodeJ) ? CodeI : s_tdata[9:5];
	assign b_in  = s_tdata[10] ? b_raw : CodeX;

	assign adv2     = !v_s2 || m_tready;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= s_tvalid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			op_s1 <= s_tuser;
			a_s1  <= a_in;
			b_s1  <= b_in;
		end
		if (adv2 && v_s1) begin
			res_s2 <= res;
		end
	end

	pf_locate u_loc_a (
		.cells  (cells),
		.letter (a_s1),
		.loc    (loc_a)
	);

	pf_locate u_loc_b (
		.cells  (cells),
		.letter (b_s1),
		.loc    (loc_b)
	);

	pf_rule u_rule (
		.cells (cells),
		.op    (op_s1),
		.loc_a (loc_a),
		.loc_b (loc_b),
		.res   (res)
	);

	assign m_tvalid = v_s2;
	assign m_tdata  = {6'b0, res_s2.second, res_s2.first};
	assign m_tuser  = res_s2.bad;

	// A flagged pair always carries zero letters.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("flagged result with nonzero letters");

	// Intake only stops when both stages are full and the output is stalled.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && v_s2 && !m_tready)
		else $error("input stalled with a free stage");

	// An input transaction lands in the input stage.
	a_in_land: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted pair lost at input stage");

	// A pair in the input stage moves on when the result stage opens.
	a_s1_move: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv2 |=> m_tvalid)
		else $error("pair lost between stages");

endmodule

FILE: src/pf_locate.sv
// ----------------------------------------------------------------------------
// pf_locate
// Finds a letter in the key square; the lowest matching cell wins.
// ----------------------------------------------------------------------------
module pf_locate
	import pf_pkg::*;
(
	input  cell_arr_t        cells,
	input  logic [CellW-1:0] letter,
	output loc_t             loc
);

	always_comb begin
		loc = '0;
		// Walk from the last cell back so that the lowest index is kept.
		for (int r = SqDim - 1; r >= 0; r--) begin
			for (int c = SqDim - 1; c >= 0; c--) begin
				if (cells[r * SqDim + c] == letter) begin
					loc.found = 1'b1;
					loc.row   = PosW'(r);
					loc.col   = PosW'(c);
				end
			end
		end
		// Codes above z never match, even if a cell holds the same bits.
		if (letter > CodeMax) begin
			loc = '0;
		end
	end

endmodule

FILE: src/pf_rule.sv
// ----------------------------------------------------------------------------
// pf_rule
// Applies the column, row or rectangle rule and reads the new letters.
// ----------------------------------------------------------------------------
module pf_rule
	import pf_pkg::*;
(
	input  cell_arr_t cells,
	input  logic      op,
	input  loc_t      loc_a,
	input  loc_t      loc_b,
	output res_t      res
);

	logic [PosW-1:0] row_a, col_a, row_b, col_b;
	logic [CellW-1:0] idx_a, idx_b;

	function automatic logic [PosW-1:0] wrap_step(input logic [PosW-1:0] v, input logic dec);
		logic [PosW-1:0] n;
		if (dec == OpDecrypt) begin
			n = (v == '0) ? PosW'(SqDim - 1) : v - PosW'(1);
		end else begin
			n = (v == PosW'(SqDim - 1)) ? '0 : v + PosW'(1);
		end
		return n;
	endfunction

	always_comb begin
		row_a = loc_a.row;
		col_a = loc_a.col;
		row_b = loc_b.row;
		col_b = loc_b.col;
		// Same column is checked first, so a doubled letter takes this branch.
		if (loc_a.col == loc_b.col) begin
			row_a = wrap_step(loc_a.row, op);
			row_b = wrap_step(loc_b.row, op);
		end else if (loc_a.row == loc_b.row) begin
			col_a = wrap_step(loc_a.col, op);
			col_b = wrap_step(loc_b.col, op);
		end else begin
			col_a = loc_b.col;
			col_b = loc_a.col;
		end
		idx_a = CellW'(row_a) * CellW'(SqDim) + CellW'(col_a);
		idx_b = CellW'(row_b) * CellW'(SqDim) + CellW'(col_b);

		if (loc_a.found && loc_b.found) begin
			res.bad    = 1'b0;
			res.first  = cells[idx_a];
			res.second = cells[idx_b];
		end else begin
			res = '0;
			res.bad = 1'b1;
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the letter pair substitution block. A local
// predictor keeps its own copy of the key square and works out every
// substituted pair; a receiver process compares each result transaction with
// the oldest pending prediction. Both stream sides idle at random, and the
// key square is reloaded between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import pf_pkg::*;

	localparam int unsigned IdleLimit = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [59:0] cfg_wdata = '0;

	cell_arr_t key_sq = '0;
	res_t      pending_pairs[$];
	int        mismatch_count = 0;
	int        idle_cycles = 0;
	int        long_hold = 0;
	int        rx_wait = 0;
	bit        no_idle = 1'b0;
	bit        out_took;
	res_t      want;

	playfair_digraph_cipher_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CellW-1:0] code_of(byte c);
		return CellW'(c - "a");
	endfunction

	// Mostly real letters, now and then a code that no cell can match.
	function automatic logic [CellW-1:0] rand_code();
		if ($urandom_range(0, 9) == 0)
			return CellW'($urandom_range(26, 31));
		return CellW'($urandom_range(0, 25));
	endfunction

	// A shuffled square of the 25 letters without j, or fully random cells.
	function automatic cell_arr_t rand_square(bit wild);
		cell_arr_t sq;
		logic [CellW-1:0] t;
		int n;
		int pick;
		n = 0;
		for (int c = 0; c <= int'(CodeMax); c++) begin
			if (c != int'(CodeJ)) begin
				sq[n] = CellW'(c);
				n++;
			end
		end
		for (int k = SqCells - 1; k > 0; k--) begin
			pick = $urandom_range(0, k);
			t = sq[k];
			sq[k] = sq[pick];
			sq[pick] = t;
		end
		if (wild)
			for (int k = 0; k < SqCells; k++)
				sq[k] = CellW'($urandom_range(0, 31));
		return sq;
	endfunction

	function automatic res_t substitute_pair(logic op, logic [CellW-1:0] a_in,
			logic [CellW-1:0] b_in, logic pres);
		logic [CellW-1:0] a;
		logic [CellW-1:0] b;
		int ia;
		int ib;
		int r1;
		int c1;
		int r2;
		int c2;
		int t;
		int step;
		res_t r;
		a = (a_in == CodeJ) ? CodeI : a_in;
		b = !pres ? CodeX : ((b_in == CodeJ) ? CodeI : b_in);
		ia = -1;
		ib = -1;
		// Scanning downward leaves the lowest matching cell in the index.
		for (int k = SqCells - 1; k >= 0; k--) begin
			if (a <= CodeMax && key_sq[k] == a)
				ia = k;
			if (b <= CodeMax && key_sq[k] == b)
				ib = k;
		end
		r = '0;
		if (ia < 0 || ib < 0) begin
			r.bad = 1'b1;
			return r;
		end
		step = (op == OpDecrypt) ? int'(SqDim) - 1 : 1;
		r1 = ia / int'(SqDim);
		c1 = ia % int'(SqDim);
		r2 = ib / int'(SqDim);
		c2 = ib % int'(SqDim);
		if (c1 == c2) begin
			r1 = (r1 + step) % int'(SqDim);
			r2 = (r2 + step) % int'(SqDim);
		end else if (r1 == r2) begin
			c1 = (c1 + step) % int'(SqDim);
			c2 = (c2 + step) % int'(SqDim);
		end else begin
			t = c1;
			c1 = c2;
			c2 = t;
		end
		r.first = key_sq[r1 * int'(SqDim) + c1];
		r.second = key_sq[r2 * int'(SqDim) + c2];
		return r;
	endfunction

	// Writes all three square registers, low, high and last, one after another.
	task automatic load_square(input cell_arr_t sq);
		logic [63:0] junk;
		junk = {$urandom(), $urandom()};
		cfg_we <= 1'b1;
		cfg_index <= RegCellsLow;
		cfg_wdata <= sq[11:0];
		@(posedge clk);
		cfg_index <= RegCellsHigh;
		cfg_wdata <= sq[23:12];
		@(posedge clk);
		// Bits above the last cell are ignored by the register.
		cfg_index <= RegCellLast;
		cfg_wdata <= {junk[54:0], sq[24]};
		@(posedge clk);
		cfg_we <= 1'b0;
		key_sq = sq;
	endtask

	task automatic offer_pair(input logic op, input logic [CellW-1:0] a,
			input logic [CellW-1:0] b, input logic pres);
		int gap;
		bit took;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, pres, b, a};
		s_tuser <= op;
		// Ready is settled by the falling edge, so sample it there.
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		pending_pairs.push_back(substitute_pair(op, a, b, pres));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_reset_square();
		offer_pair(OpEncrypt, code_of("a"), code_of("a"), 1'b1);
		offer_pair(OpDecrypt, code_of("a"), code_of("a"), 1'b1);
		offer_pair(OpEncrypt, code_of("a"), code_of("b"), 1'b1);
		offer_pair(OpEncrypt, code_of("a"), code_of("a"), 1'b0);
		wait_idle();
	endtask

	task automatic test_directed_rules();
		cell_arr_t sq;
		string key;
		key = "playfirexmbcdghknoqstuvwz";
		for (int k = 0; k < SqCells; k++)
			sq[k] = code_of(key[k]);
		load_square(sq);
		// Rectangle, both directions.
		offer_pair(OpEncrypt, code_of("h"), code_of("i"), 1'b1);
		offer_pair(OpDecrypt, code_of("h"), code_of("i"), 1'b1);
		// Same row, including the wrap at the right edge.
		offer_pair(OpEncrypt, code_of("p"), code_of("l"), 1'b1);
		offer_pair(OpEncrypt, code_of("y"), code_of("f"), 1'b1);
		offer_pair(OpDecrypt, code_of("y"), code_of("p"), 1'b1);
		// Same column, including the wrap at top and bottom.
		offer_pair(OpEncrypt, code_of("p"), code_of("t"), 1'b1);
		offer_pair(OpDecrypt, code_of("p"), code_of("t"), 1'b1);
		offer_pair(OpEncrypt, code_of("a"), code_of("d"), 1'b1);
		// Two equal letters follow the column rule.
		offer_pair(OpEncrypt, code_of("a"), code_of("a"), 1'b1);
		offer_pair(OpDecrypt, code_of("z"), code_of("z"), 1'b1);
		// The letter j stands for i in either position.
		offer_pair(OpEncrypt, code_of("j"), code_of("x"), 1'b1);
		offer_pair(OpDecrypt, code_of("p"), code_of("j"), 1'b1);
		// Missing second letter becomes x; the second field is then unused.
		offer_pair(OpEncrypt, code_of("m"), 5'd31, 1'b0);
		offer_pair(OpDecrypt, code_of("j"), 5'd26, 1'b0);
		// Codes above z are never found; a and z at the ends of the range still are.
		offer_pair(OpEncrypt, 5'd31, code_of("a"), 1'b1);
		offer_pair(OpEncrypt, 5'd26, code_of("b"), 1'b1);
		offer_pair(OpDecrypt, code_of("c"), 5'd30, 1'b1);
		offer_pair(OpEncrypt, 5'd0, 5'd25, 1'b1);
		offer_pair(OpDecrypt, 5'd25, 5'd0, 1'b1);
		wait_idle();
		// A repeated letter is found at its lowest cell; z is gone and the
		// corner cell holds a code that no letter matches but is still output.
		sq[12] = code_of("a");
		sq[24] = 5'd31;
		load_square(sq);
		offer_pair(OpEncrypt, code_of("a"), code_of("x"), 1'b1);
		offer_pair(OpEncrypt, code_of("w"), code_of("s"), 1'b1);
		offer_pair(OpDecrypt, code_of("z"), code_of("p"), 1'b1);
		wait_idle();
		load_square('1);
		offer_pair(OpEncrypt, code_of("b"), code_of("c"), 1'b1);
		offer_pair(OpDecrypt, 5'd31, 5'd31, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_pairs();
		cell_arr_t sq;
		logic [CellW-1:0] t;
		for (int p = 0; p < 5; p++) begin
			sq = rand_square(p == 2);
			if (p == 0) begin
				// Put z in the corner so the last register sees its top code.
				for (int k = 0; k < SqCells; k++) begin
					if (sq[k] == CodeMax) begin
						t = sq[24];
						sq[24] = sq[k];
						sq[k] = t;
					end
				end
			end
			load_square(sq);
			no_idle = (p == 3);
			for (int n = 0; n < 110; n++)
				offer_pair(logic'($urandom_range(0, 1)), rand_code(),
					($urandom_range(0, 4) == 0) ? CellW'($urandom_range(0, 31))
						: rand_code(),
					logic'($urandom_range(0, 4) != 0));
			wait_idle();
		end
		no_idle = 1'b0;
	endtask

	// The receiver holds off long enough that both stages fill and the input
	// stalls while the sender keeps offering back to back.
	task automatic test_output_stall();
		load_square(rand_square(1'b0));
		no_idle = 1'b1;
		long_hold = 60;
		for (int n = 0; n < 40; n++)
			offer_pair(logic'($urandom_range(0, 1)), rand_code(), rand_code(),
				logic'($urandom_range(0, 1)));
		wait_idle();
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_square();
		test_directed_rules();
		test_output_stall();
		test_random_pairs();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_pairs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Result side: compare at the falling edge, then choose the next ready.
	initial begin
		forever begin
			@(negedge clk);
			out_took = m_tvalid && m_tready;
			if (out_took) begin
				if (pending_pairs.size() == 0) begin
					$display("%0t: result with nothing pending, got %h/%b", $time,
						m_tdata, m_tuser);
					mismatch_count++;
				end else begin
					want = pending_pairs.pop_front();
					if (m_tdata[4:0] !== want.first) begin
						$display("%0t: out_first expected %0d got %0d", $time,
							want.first, m_tdata[4:0]);
						mismatch_count++;
					end
					if (m_tdata[9:5] !== want.second) begin
						$display("%0t: out_second expected %0d got %0d", $time,
							want.second, m_tdata[9:5]);
						mismatch_count++;
					end
					if (m_tuser !== want.bad) begin
						$display("%0t: bad_letter expected %b got %b", $time,
							want.bad, m_tuser);
						mismatch_count++;
					end
				end
			end
			@(posedge clk);
			if (long_hold > 0) begin
				m_tready <= 1'b0;
				long_hold--;
			end else if (out_took && !no_idle) begin
				rx_wait = $urandom_range(0, 5);
				m_tready <= (rx_wait == 0);
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= (rx_wait == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
